// File: src/deq_pkg.sv
// Shared types, command codes and constants of the double-ended queue.
package deq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CMD_W = 3;
	localparam int unsigned CNT_W = 5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam cmd_t CMD_INS_REAR = 3'd0;
	localparam cmd_t CMD_INS_FRONT = 3'd1;
	localparam cmd_t CMD_DEL_REAR = 3'd2;
	localparam cmd_t CMD_DEL_FRONT = 3'd3;

	localparam word_t EMPTY_WORD = '1;

endpackage

// File: src/deq_mem.sv
// Entry store: one write port and two registered read ports.
module deq_mem #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [AW-1:0] wr_addr,
	input  deq_pkg::word_t wr_data,
	input  logic rd_en,
	input  logic [AW-1:0] rd_front_addr,
	input  logic [AW-1:0] rd_rear_addr,
	output deq_pkg::word_t rd_front_data,
	output deq_pkg::word_t rd_rear_data
);
	import deq_pkg::*;

	word_t mem_q [DEPTH];
	word_t rd_front_q;
	word_t rd_rear_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_front_q <= mem_q[rd_front_addr];
			rd_rear_q <= mem_q[rd_rear_addr];
		end
	end

	assign rd_front_data = rd_front_q;
	assign rd_rear_data = rd_rear_q;

endmodule

// File: src/deq_ptr.sv
// Head, tail and occupancy registers with the command decode.
module deq_ptr #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
	parameter int unsigned AW = $clog2(DEPTH),
	parameter int unsigned CW = $clog2(DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  deq_pkg::cmd_t command,
	output logic wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [AW-1:0] rd_front_addr,
	output logic [AW-1:0] rd_rear_addr,
	output logic [CW-1:0] count,
	output logic overflow
);
	import deq_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic [AW-1:0] head_prev, head_next, tail_prev, tail_next;
	logic [CW-1:0] cnt_q, cnt_d;
	logic ovf_q, ovf_d, full, empty, write_d;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head_prev = (head_q == '0) ? LAST : head_q - 1'b1;
	assign head_next = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST : tail_q - 1'b1;
	assign tail_next = (tail_q == LAST) ? '0 : tail_q + 1'b1;

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		cnt_d = cnt_q;
		ovf_d = 1'b0;
		write_d = 1'b0;
		wr_addr = tail_q;
		case (command)
			CMD_INS_REAR: begin
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					write_d = 1'b1;
					tail_d = tail_next;
					cnt_d = cnt_q + 1'b1;
				end
			end
			CMD_INS_FRONT: begin
				wr_addr = head_prev;
				if (full) begin
					ovf_d = 1'b1;
				end else begin
					write_d = 1'b1;
					head_d = head_prev;
					cnt_d = cnt_q + 1'b1;
				end
			end
			CMD_DEL_REAR: begin
				if (!empty) begin
					tail_d = tail_prev;
					cnt_d = cnt_q - 1'b1;
				end
			end
			CMD_DEL_FRONT: begin
				if (!empty) begin
					head_d = head_next;
					cnt_d = cnt_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q <= cnt_d;
			ovf_q <= ovf_d;
		end
	end

	assign wr_en = accept & write_d;
	assign rd_front_addr = head_q;
	assign rd_rear_addr = tail_prev;
	assign count = cnt_q;
	assign overflow = ovf_q;

endmodule

// File: src/double_ended_queue_core.sv
// Top level of the double-ended queue over a circular entry store.
// An accepted request updates the pointers and sets busy; no new request is taken while busy.
// Busy then enables the registered read of the store and raises out_valid with its data.
// A new request is taken in the cycle the pending result is taken.
// Reset clears the pointers, the count and the handshake state; the store is not cleared.
module double_ended_queue_core #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  deq_pkg::cmd_t command,
	input  logic signed [deq_pkg::WORD_W-1:0] value,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [deq_pkg::WORD_W-1:0] front_value,
	output logic signed [deq_pkg::WORD_W-1:0] rear_value,
	output logic is_empty,
	output deq_pkg::cnt_t entry_count,
	output logic overflow
);
	import deq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic busy_q, out_valid_q, accept, wr_en, ovf;
	logic [AW-1:0] wr_addr, rd_front_addr, rd_rear_addr;
	logic [CW-1:0] count;
	logic [CW+CNT_W-1:0] count_ext;
	word_t rd_front_data, rd_rear_data;

	assign in_ready = !busy_q && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;

	deq_ptr #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ptr (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.command(command),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.rd_front_addr(rd_front_addr),
		.rd_rear_addr(rd_rear_addr),
		.count(count),
		.overflow(ovf)
	);

	deq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(word_t'(value)),
		.rd_en(busy_q),
		.rd_front_addr(rd_front_addr),
		.rd_rear_addr(rd_rear_addr),
		.rd_front_data(rd_front_data),
		.rd_rear_data(rd_rear_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			busy_q <= accept;
			if (busy_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign count_ext = {{CNT_W{1'b0}}, count};
	assign is_empty = (count == '0);
	assign entry_count = count_ext[CNT_W-1:0];
	assign overflow = ovf;
	assign front_value = is_empty ? EMPTY_WORD : rd_front_data;
	assign rear_value = is_empty ? EMPTY_WORD : rd_rear_data;
	assign out_valid = out_valid_q;

endmodule

// File: src/deq_checker.sv
// Port-level checks of the double-ended queue and their binding.
module deq_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [deq_pkg::WORD_W-1:0] front_value,
	input logic signed [deq_pkg::WORD_W-1:0] rear_value,
	input logic is_empty,
	input deq_pkg::cnt_t entry_count,
	input logic overflow
);
	import deq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(front_value) && $stable(rear_value))
		else $error("Result changed while stalled.");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> front_value == EMPTY_WORD && rear_value == EMPTY_WORD
			&& entry_count == '0)
		else $error("Empty deque did not report empty words and zero count.");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("Result shown in the cycle after a request was taken.");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !is_empty)
		else $error("Overflow reported on an empty deque.");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.front_value(front_value),
	.rear_value(rear_value),
	.is_empty(is_empty),
	.entry_count(entry_count),
	.overflow(overflow)
);

// File: tb/sv/deque_status_check.sv
// Checker that predicts and compares every result of the double-ended queue.
module deque_status_check #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  deq_pkg::cmd_t command,
	input  deq_pkg::word_t value,
	input  logic out_valid,
	input  logic out_ready,
	input  deq_pkg::word_t front_value,
	input  deq_pkg::word_t rear_value,
	input  logic is_empty,
	input  deq_pkg::cnt_t entry_count,
	input  logic overflow,
	output int pending,
	output int mismatches
);
	import deq_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		word_t front;
		word_t rear;
		logic empty;
		cnt_t count;
		logic dropped;
	} deque_status_t;

	word_t slots [DEPTH];
	int unsigned head_slot;
	int unsigned tail_slot;
	int unsigned held;
	deque_status_t status_q [$];
	deque_status_t seen;
	deque_status_t want;

	initial begin
		pending = 0;
		mismatches = 0;
	end

	function automatic int unsigned slot_after(int unsigned i);
		return (i + 1 >= DEPTH) ? 0 : i + 1;
	endfunction

	function automatic int unsigned slot_before(int unsigned i);
		return (i == 0) ? DEPTH - 1 : i - 1;
	endfunction

	function automatic deque_status_t apply_command(cmd_t cmd, word_t word);
		deque_status_t s;
		s.dropped = 1'b0;
		case (cmd)
			CMD_INS_REAR: begin
				if (held >= DEPTH) begin
					s.dropped = 1'b1;
				end else begin
					slots[tail_slot] = word;
					tail_slot = slot_after(tail_slot);
					held++;
				end
			end
			CMD_INS_FRONT: begin
				if (held >= DEPTH) begin
					s.dropped = 1'b1;
				end else begin
					head_slot = slot_before(head_slot);
					slots[head_slot] = word;
					held++;
				end
			end
			CMD_DEL_REAR: begin
				if (held != 0) begin
					tail_slot = slot_before(tail_slot);
					held--;
				end
			end
			CMD_DEL_FRONT: begin
				if (held != 0) begin
					head_slot = slot_after(head_slot);
					held--;
				end
			end
			default: begin
			end
		endcase
		if (held == 0) begin
			s.front = EMPTY_WORD;
			s.rear = EMPTY_WORD;
			s.empty = 1'b1;
		end else begin
			s.front = slots[head_slot];
			s.rear = slots[slot_before(tail_slot)];
			s.empty = 1'b0;
		end
		s.count = cnt_t'(held);
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot = 0;
			tail_slot = 0;
			held = 0;
			status_q.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {front_value, rear_value, is_empty, entry_count, overflow};
				if (status_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected result: front=%h rear=%h empty=%b count=%0d ovf=%b",
							seen.front, seen.rear, seen.empty, seen.count, seen.dropped);
				end else begin
					want = status_q.pop_front();
					if (seen !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("expected front=%h rear=%h empty=%b count=%0d ovf=%b",
								want.front, want.rear, want.empty, want.count, want.dropped);
							$display("  actual front=%h rear=%h empty=%b count=%0d ovf=%b",
								seen.front, seen.rear, seen.empty, seen.count, seen.dropped);
						end
					end
				end
			end
			if (in_valid && in_ready)
				status_q.push_back(apply_command(command, value));
			pending = status_q.size();
		end
	end

endmodule

// File: tb/sv/double_ended_queue_core_tb.sv
// Top of the double-ended queue testbench: clock, reset, requests and verdict.
module double_ended_queue_core_tb;
	import deq_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEF;
	localparam int RANDOM_REQUESTS = 1500;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam cmd_t CMD_QUERY = 3'd4;
	localparam cmd_t CMD_LAST = '1;
	localparam word_t WORD_MAX = 32'h7FFF_FFFF;
	localparam word_t WORD_MIN = 32'h8000_0000;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} request_mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cmd_t command = CMD_QUERY;
	word_t value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	word_t front_value;
	word_t rear_value;
	logic is_empty;
	cnt_t entry_count;
	logic overflow;
	int pending;
	int mismatches;
	int burst_left = 0;
	int idle_cycles = 0;
	int ready_mode = 0;
	int ready_left = 0;
	int unsigned tick = 0;

	always #1 clk = ~clk;

	double_ended_queue_core #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.front_value(front_value),
		.rear_value(rear_value),
		.is_empty(is_empty),
		.entry_count(entry_count),
		.overflow(overflow)
	);

	deque_status_check #(.DEPTH(DEPTH)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.front_value(front_value),
		.rear_value(rear_value),
		.is_empty(is_empty),
		.entry_count(entry_count),
		.overflow(overflow),
		.pending(pending),
		.mismatches(mismatches)
	);

	// The receiver switches between steady acceptance, light and heavy stalling,
	// and a fixed one-in-three pattern.
	always @(posedge clk) begin
		tick <= tick + 1;
		if (ready_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			ready_left <= $urandom_range(10, 80);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (tick % 3 == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic issue(input cmd_t cmd, input word_t word);
		in_valid <= 1'b1;
		command <= cmd;
		value <= word;
		do @(posedge clk); while (!in_ready);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t pick_command(request_mix_t mix);
		int roll;
		int ins_pct;
		roll = $urandom_range(0, 99);
		ins_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 42;
		if (roll < ins_pct)
			return $urandom_range(0, 1) ? CMD_INS_REAR : CMD_INS_FRONT;
		else if (roll < 92)
			return $urandom_range(0, 1) ? CMD_DEL_REAR : CMD_DEL_FRONT;
		else
			return cmd_t'($urandom_range(CMD_QUERY, CMD_LAST));
	endfunction

	initial begin
		int sent;
		int run_left;
		request_mix_t mix;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_QUERY, $urandom);
		issue(CMD_DEL_REAR, $urandom);
		issue(CMD_DEL_FRONT, $urandom);
		issue(CMD_INS_REAR, WORD_MAX);
		issue(CMD_INS_FRONT, WORD_MIN);
		issue(CMD_INS_REAR, '1);
		issue(CMD_INS_FRONT, '0);
		for (int c = CMD_QUERY; c <= CMD_LAST; c++)
			issue(cmd_t'(c), $urandom);
		issue(CMD_DEL_REAR, $urandom);
		issue(CMD_DEL_FRONT, $urandom);
		issue(CMD_DEL_REAR, $urandom);
		issue(CMD_DEL_FRONT, $urandom);
		issue(CMD_DEL_REAR, $urandom);
		issue(CMD_DEL_FRONT, $urandom);
		wait_drained();

		sent = 0;
		run_left = 0;
		mix = MIX_EVEN;
		while (sent < RANDOM_REQUESTS) begin
			if (run_left == 0) begin
				mix = request_mix_t'($urandom_range(0, 2));
				run_left = $urandom_range(20, 60);
			end
			issue(pick_command(mix), pick_word());
			run_left--;
			sent++;
			if (sent % 400 == 0)
				wait_drained();
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
